>>> src/ookfe_pkg.sv
// Package for the remote-control frame encoder: item, result, configuration
// and sequencer state types, register indexes and reset values.
// No dependencies.
package ookfe_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 26;

    localparam logic [CFG_INDEX_W-1:0] REG_TRANSMITTER_ID  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_COUNT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_LOW_TICKS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_LOW_TICKS  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_LOW_TICKS  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_TICKS       = 3'd5;

    localparam logic [25:0] TRANSMITTER_ID_RST  = 26'd43132401;
    localparam logic [3:0]  REPEAT_COUNT_RST    = 4'd4;
    localparam logic [3:0]  SHORT_LOW_TICKS_RST = 4'd1;
    localparam logic [3:0]  LONG_LOW_TICKS_RST  = 4'd5;
    localparam logic [5:0]  SYNC_LOW_TICKS_RST  = 6'd10;
    localparam logic [7:0]  GAP_TICKS_RST       = 8'd40;

    localparam logic [4:0]  FIRST_BIT = 5'd31;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SYNC  = 3'd1,
        PH_BITS  = 3'd2,
        PH_TRAIL = 3'd3,
        PH_GAP   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [25:0] transmitter_id;
        logic [3:0]  repeat_count;
        logic [3:0]  short_low_ticks;
        logic [3:0]  long_low_ticks;
        logic [5:0]  sync_low_ticks;
        logic [7:0]  gap_ticks;
    } cfg_t;

    typedef struct packed {
        logic       func;
        logic       on_off;
        logic [1:0] channel;
        logic [1:0] button;
    } item_t;

    typedef struct packed {
        logic rf_level;
        logic busy_res;
        logic accepted;
        logic last;
    } result_t;

    typedef struct packed {
        logic [31:0] frame_bits;
        phase_t      phase;
        logic [4:0]  bit_index;
        logic        half_index;
        logic [7:0]  tick_count;
        logic [3:0]  repeat_left;
    } seq_state_t;

endpackage

>>> src/ookfe_item_if.sv
// Input item channel of the frame encoder: valid/ready plus item fields.
// No dependencies.
interface ookfe_item_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic       on_off;
    logic [1:0] channel;
    logic [1:0] button;

    modport source (output valid, func, on_off, channel, button, input ready);
    modport sink   (input valid, func, on_off, channel, button, output ready);
endinterface

>>> src/ookfe_result_if.sv
// Result channel of the frame encoder: valid/ready plus result fields.
// No dependencies.
interface ookfe_result_if;
    logic valid;
    logic ready;
    logic rf_level;
    logic busy_res;
    logic accepted;
    logic last;

    modport source (output valid, rf_level, busy_res, accepted, last, input ready);
    modport sink   (input valid, rf_level, busy_res, accepted, last, output ready);
endinterface

>>> src/ookfe_cfg_if.sv
// Configuration write channel of the frame encoder: valid/ready, index, data.
// Depends on ookfe_pkg.
interface ookfe_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ookfe_pkg::CFG_INDEX_W-1:0]  index;
    logic [ookfe_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/ook_remote_frame_encoder_unit.sv
// Top level of the on-off keyed remote-control frame encoder.
// Depends on ookfe_pkg, ookfe_item_if, ookfe_result_if, ookfe_cfg_if, ookfe_step.
//
// Each input item is either a start (when idle, latches the 32-bit frame and
// begins a message) or a tick (one base period, giving the RF line level). Every item
// yields exactly one result, in the cycle after its transfer. The block takes one
// item per cycle: the sequencer step is a single pass of logic from the state
// registers into the result register, and the input stalls only while that
// result register is full and not being taken. Configuration writes complete
// in the cycle they are offered; pulse and gap lengths are read live, id and
// repeat count are captured at start.
module ook_remote_frame_encoder_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    ookfe_item_if.sink             item,
    ookfe_result_if.source         result,
    ookfe_cfg_if.sink              cfg
);

    ookfe_pkg::cfg_t       cfg_reg;
    ookfe_pkg::seq_state_t state_reg;
    ookfe_pkg::seq_state_t state_next;
    ookfe_pkg::result_t    res_reg;
    ookfe_pkg::result_t    res_next;
    ookfe_pkg::item_t      item_in;
    logic                  res_valid_reg;
    logic                  item_xfer;

    assign item_in   = '{func: item.func, on_off: item.on_off,
                         channel: item.channel, button: item.button};
    assign item.ready = ~res_valid_reg | result.ready;
    assign item_xfer  = item.valid & item.ready;
    assign cfg.ready  = 1'b1;

    ookfe_step u_step (
        .st      (state_reg),
        .cfg     (cfg_reg),
        .item    (item_in),
        .st_next (state_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.transmitter_id  <= ookfe_pkg::TRANSMITTER_ID_RST;
            cfg_reg.repeat_count    <= ookfe_pkg::REPEAT_COUNT_RST;
            cfg_reg.short_low_ticks <= ookfe_pkg::SHORT_LOW_TICKS_RST;
            cfg_reg.long_low_ticks  <= ookfe_pkg::LONG_LOW_TICKS_RST;
            cfg_reg.sync_low_ticks  <= ookfe_pkg::SYNC_LOW_TICKS_RST;
            cfg_reg.gap_ticks       <= ookfe_pkg::GAP_TICKS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ookfe_pkg::REG_TRANSMITTER_ID:  cfg_reg.transmitter_id  <= cfg.data[25:0];
                ookfe_pkg::REG_REPEAT_COUNT:    cfg_reg.repeat_count    <= cfg.data[3:0];
                ookfe_pkg::REG_SHORT_LOW_TICKS: cfg_reg.short_low_ticks <= cfg.data[3:0];
                ookfe_pkg::REG_LONG_LOW_TICKS:  cfg_reg.long_low_ticks  <= cfg.data[3:0];
                ookfe_pkg::REG_SYNC_LOW_TICKS:  cfg_reg.sync_low_ticks  <= cfg.data[5:0];
                ookfe_pkg::REG_GAP_TICKS:       cfg_reg.gap_ticks       <= cfg.data[7:0];
                default:                        cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.frame_bits  <= '0;
            state_reg.phase       <= ookfe_pkg::PH_IDLE;
            state_reg.bit_index   <= '0;
            state_reg.half_index  <= 1'b0;
            state_reg.tick_count  <= '0;
            state_reg.repeat_left <= '0;
        end
        else if (item_xfer)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (item_xfer)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
            res_reg <= res_next;
    end

    assign result.valid    = res_valid_reg;
    assign result.rf_level = res_reg.rf_level;
    assign result.busy_res = res_reg.busy_res;
    assign result.accepted = res_reg.accepted;
    assign result.last     = res_reg.last;

endmodule

>>> src/ookfe_step.sv
// Frame sequencer step: next sequencer state and result for one item.
// Depends on ookfe_pkg.
module ookfe_step (
    input  ookfe_pkg::seq_state_t st,
    input  ookfe_pkg::cfg_t       cfg,
    input  ookfe_pkg::item_t      item,
    output ookfe_pkg::seq_state_t st_next,
    output ookfe_pkg::result_t    res
);

    function automatic ookfe_pkg::seq_state_t close_frame(ookfe_pkg::seq_state_t s);
        ookfe_pkg::seq_state_t r;
        r = s;
        if (s.repeat_left != 4'd0)
            r.repeat_left = s.repeat_left - 4'd1;
        r.tick_count = 8'd0;
        r.half_index = 1'b0;
        if (r.repeat_left == 4'd0)
        begin
            r.phase     = ookfe_pkg::PH_IDLE;
            r.bit_index = 5'd0;
        end
        else
        begin
            r.phase     = ookfe_pkg::PH_SYNC;
            r.bit_index = ookfe_pkg::FIRST_BIT;
        end
        return r;
    endfunction

    logic       cur_bit;
    logic       is_long;
    logic [5:0] pulse_low;

    always_comb
    begin
        cur_bit = st.frame_bits[st.bit_index];
        is_long = st.half_index ? cur_bit : ~cur_bit;
        case (st.phase)
            ookfe_pkg::PH_SYNC: pulse_low = cfg.sync_low_ticks;
            ookfe_pkg::PH_BITS: pulse_low = is_long ? {2'b00, cfg.long_low_ticks}
                                                    : {2'b00, cfg.short_low_ticks};
            default:            pulse_low = {2'b00, cfg.short_low_ticks};
        endcase
    end

    always_comb
    begin
        st_next = st;
        if (item.func)
        begin
            if (st.phase == ookfe_pkg::PH_IDLE)
            begin
                st_next.frame_bits  = {cfg.transmitter_id, 1'b1, item.on_off,
                                       item.channel[0], item.channel[1],
                                       item.button[0], item.button[1]};
                st_next.repeat_left = (cfg.repeat_count == 4'd0) ? 4'd1 : cfg.repeat_count;
                st_next.phase       = ookfe_pkg::PH_SYNC;
                st_next.bit_index   = ookfe_pkg::FIRST_BIT;
                st_next.half_index  = 1'b0;
                st_next.tick_count  = 8'd0;
            end
        end
        else if (st.phase != ookfe_pkg::PH_IDLE)
        begin
            if (st.phase == ookfe_pkg::PH_GAP)
            begin
                if ({1'b0, st.tick_count} + 9'd1 >= {1'b0, cfg.gap_ticks})
                    st_next = close_frame(st);
                else
                    st_next.tick_count = st.tick_count + 8'd1;
            end
            else
            begin
                if (st.tick_count >= {2'b00, pulse_low})
                begin
                    st_next.tick_count = 8'd0;
                    case (st.phase)
                        ookfe_pkg::PH_SYNC:
                        begin
                            st_next.phase      = ookfe_pkg::PH_BITS;
                            st_next.bit_index  = ookfe_pkg::FIRST_BIT;
                            st_next.half_index = 1'b0;
                        end
                        ookfe_pkg::PH_BITS:
                        begin
                            if (!st.half_index)
                                st_next.half_index = 1'b1;
                            else
                            begin
                                st_next.half_index = 1'b0;
                                if (st.bit_index == 5'd0)
                                    st_next.phase = ookfe_pkg::PH_TRAIL;
                                else
                                    st_next.bit_index = st.bit_index - 5'd1;
                            end
                        end
                        default:
                        begin
                            if (cfg.gap_ticks == 8'd0)
                                st_next = close_frame(st);
                            else
                                st_next.phase = ookfe_pkg::PH_GAP;
                        end
                    endcase
                end
                else
                    st_next.tick_count = st.tick_count + 8'd1;
            end
        end
    end

    // the message ends on the tick that drops the sequencer back to idle
    always_comb
    begin
        res = '0;
        if (item.func)
        begin
            res.accepted = (st.phase == ookfe_pkg::PH_IDLE);
            res.busy_res = 1'b1;
        end
        else if (st.phase != ookfe_pkg::PH_IDLE)
        begin
            res.busy_res = 1'b1;
            res.rf_level = (st.phase != ookfe_pkg::PH_GAP) && (st.tick_count == 8'd0);
            res.last     = (st_next.phase == ookfe_pkg::PH_IDLE);
        end
    end

endmodule

>>> test/ookfe_encoder_checker.sv
// Checker for the remote-control frame encoder: watches the item, result and
// configuration channels, predicts each result and compares its fields.
// Depends on ookfe_pkg, ookfe_item_if, ookfe_result_if, ookfe_cfg_if.
`timescale 1ns / 1ps

module ookfe_encoder_checker
    import ookfe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    ookfe_item_if   item,
    ookfe_result_if result,
    ookfe_cfg_if    cfg,
    output int      mismatches,
    output int      outstanding,
    output logic    msg_active
);

    cfg_t        regs;
    logic [31:0] frame;
    phase_t      stage;
    logic [4:0]  bit_pos;
    logic        second_half;
    logic [7:0]  ticks;
    logic [3:0]  frames_left;

    result_t     awaited_results[$];
    result_t     want;
    int          results_seen;

    function automatic logic [7:0] low_len();
        logic b;
        if (stage == PH_SYNC)
            return 8'(regs.sync_low_ticks);
        if (stage == PH_BITS)
        begin
            b = frame[bit_pos];
            return (second_half ? b : !b) ? 8'(regs.long_low_ticks)
                                          : 8'(regs.short_low_ticks);
        end
        return 8'(regs.short_low_ticks);
    endfunction

    function automatic logic close_frame();
        if (frames_left != 0)
            frames_left--;
        ticks = '0;
        second_half = 1'b0;
        if (frames_left == 0)
        begin
            stage = PH_IDLE;
            bit_pos = '0;
            return 1'b1;
        end
        stage = PH_SYNC;
        bit_pos = FIRST_BIT;
        return 1'b0;
    endfunction

    function automatic result_t encoder_step(item_t it);
        result_t r;
        r = '0;
        if (it.func)
        begin
            if (stage == PH_IDLE)
            begin
                frame = {regs.transmitter_id, 1'b1, it.on_off, it.channel[0],
                         it.channel[1], it.button[0], it.button[1]};
                frames_left = (regs.repeat_count == 0) ? 4'd1 : regs.repeat_count;
                stage = PH_SYNC;
                bit_pos = FIRST_BIT;
                second_half = 1'b0;
                ticks = '0;
                r.accepted = 1'b1;
            end
            r.busy_res = 1'b1;
        end
        else if (stage != PH_IDLE)
        begin
            r.busy_res = 1'b1;
            if (stage == PH_GAP)
            begin
                if (9'(ticks) + 9'd1 >= 9'(regs.gap_ticks))
                    r.last = close_frame();
                else
                    ticks++;
            end
            else
            begin
                r.rf_level = (ticks == 0);
                if (ticks >= low_len())
                begin
                    ticks = '0;
                    case (stage)
                        PH_SYNC:
                        begin
                            stage = PH_BITS;
                            bit_pos = FIRST_BIT;
                            second_half = 1'b0;
                        end
                        PH_BITS:
                        begin
                            if (!second_half)
                                second_half = 1'b1;
                            else
                            begin
                                second_half = 1'b0;
                                if (bit_pos == 0)
                                    stage = PH_TRAIL;
                                else
                                    bit_pos--;
                            end
                        end
                        default:
                        begin
                            if (regs.gap_ticks == 0)
                                r.last = close_frame();
                            else
                                stage = PH_GAP;
                        end
                    endcase
                end
                else
                    ticks++;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        if (mismatches < 100)
            $display("[%0t] result %0d mismatch: %s", $time, results_seen, what);
        mismatches++;
    endtask

    task automatic check_field(string name, logic got, logic exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s is %b, predicted %b", name, got, exp_val));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs = '{TRANSMITTER_ID_RST, REPEAT_COUNT_RST, SHORT_LOW_TICKS_RST,
                     LONG_LOW_TICKS_RST, SYNC_LOW_TICKS_RST, GAP_TICKS_RST};
            frame = '0;
            stage = PH_IDLE;
            bit_pos = '0;
            second_half = 1'b0;
            ticks = '0;
            frames_left = '0;
            awaited_results.delete();
            results_seen = 0;
            mismatches = 0;
            outstanding <= 0;
            msg_active <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_TRANSMITTER_ID:  regs.transmitter_id  = cfg.data[25:0];
                    REG_REPEAT_COUNT:    regs.repeat_count    = cfg.data[3:0];
                    REG_SHORT_LOW_TICKS: regs.short_low_ticks = cfg.data[3:0];
                    REG_LONG_LOW_TICKS:  regs.long_low_ticks  = cfg.data[3:0];
                    REG_SYNC_LOW_TICKS:  regs.sync_low_ticks  = cfg.data[5:0];
                    REG_GAP_TICKS:       regs.gap_ticks       = cfg.data[7:0];
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
                awaited_results.push_back(encoder_step(
                    item_t'({item.func, item.on_off, item.channel, item.button})));
            if (result.valid && result.ready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result transfer with nothing predicted");
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("rf_level", result.rf_level, want.rf_level);
                    check_field("busy_res", result.busy_res, want.busy_res);
                    check_field("accepted", result.accepted, want.accepted);
                    check_field("last", result.last, want.last);
                end
                results_seen++;
            end
            outstanding <= awaited_results.size();
            msg_active <= (stage != PH_IDLE);
        end
    end

endmodule

>>> test/ook_remote_frame_encoder_unit_tb.sv
// Testbench top for the remote-control frame encoder: clock, reset, item and
// configuration stimulus, result back-pressure and the final verdict.
// Depends on ookfe_pkg, the three channel interfaces and ookfe_encoder_checker.
`timescale 1ns / 1ps

module ook_remote_frame_encoder_unit_tb;
    import ookfe_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    logic        clk = 1'b0;
    logic        rst_n;
    int          mismatches;
    int          outstanding;
    logic        msg_active;
    int unsigned cycle_count = 0;
    bit          tx_gaps = 1'b1;
    bit          rx_stalls = 1'b1;
    bit          item_raised = 1'b0;

    ookfe_item_if   item_ch();
    ookfe_result_if result_ch();
    ookfe_cfg_if    cfg_ch();

    ook_remote_frame_encoder_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    ookfe_encoder_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .msg_active  (msg_active)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic item_t pack_item(logic f, logic o, logic [1:0] c, logic [1:0] b);
        return '{func: f, on_off: o, channel: c, button: b};
    endfunction

    function automatic item_t random_item(logic f);
        item_t it;
        it = item_t'(6'($urandom_range(0, 63)));
        it.func = f;
        return it;
    endfunction

    function automatic cfg_t small_config();
        cfg_t c;
        c.transmitter_id  = 26'($urandom);
        c.repeat_count    = 4'($urandom_range(0, 3));
        c.short_low_ticks = 4'($urandom_range(0, 3));
        c.long_low_ticks  = 4'($urandom_range(0, 4));
        c.sync_low_ticks  = 6'($urandom_range(0, 6));
        c.gap_ticks       = 8'($urandom_range(0, 12));
        return c;
    endfunction

    task automatic drop_item();
        if (item_raised)
        begin
            item_ch.valid <= 1'b0;
            item_raised = 1'b0;
        end
    endtask

    task automatic send_item(item_t it);
        int unsigned hold;
        hold = tx_gaps ? $urandom_range(0, 9) : 0;
        if (hold > 0)
        begin
            drop_item();
            repeat (hold) @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.func    <= it.func;
        item_ch.on_off  <= it.on_off;
        item_ch.channel <= it.channel;
        item_ch.button  <= it.button;
        item_raised = 1'b1;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic set_config(cfg_t c);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_TRANSMITTER_ID, c.transmitter_id);
        write_reg(REG_REPEAT_COUNT, {junk[25:4], c.repeat_count});
        write_reg(REG_SHORT_LOW_TICKS, {junk[21:0], c.short_low_ticks});
        write_reg(REG_LONG_LOW_TICKS, {junk[24:3], c.long_low_ticks});
        write_reg(REG_SYNC_LOW_TICKS, {junk[19:0], c.sync_low_ticks});
        write_reg(REG_GAP_TICKS, {junk[17:0], c.gap_ticks});
        cfg_ch.valid <= 1'b0;
    endtask

    // advance with ticks until the message ends and every result is back
    task automatic finish_messages();
        drop_item();
        @(posedge clk);
        while (msg_active || outstanding != 0)
        begin
            if (msg_active)
            begin
                send_item(random_item(1'b0));
                drop_item();
            end
            @(posedge clk);
        end
    endtask

    task automatic random_items(int count);
        item_t it;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 49) == 0)
            begin
                drop_item();
                do @(posedge clk); while (outstanding != 0);
            end
            it = random_item(!msg_active || $urandom_range(0, 15) == 0);
            send_item(it);
        end
    endtask

    initial
    begin
        result_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            int unsigned stall;
            stall = rx_stalls ? $urandom_range(0, 9) : 0;
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    initial
    begin
        rst_n           <= 1'b0;
        item_ch.valid   <= 1'b0;
        item_ch.func    <= 1'b0;
        item_ch.on_off  <= 1'b0;
        item_ch.channel <= '0;
        item_ch.button  <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= '0;
        cfg_ch.data     <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: idle ticks, a start, a start while busy
        send_item(pack_item(1'b0, 1'b0, 2'd0, 2'd0));
        send_item(pack_item(1'b0, 1'b1, 2'd3, 2'd3));
        send_item(pack_item(1'b1, 1'b0, 2'd0, 2'd0));
        send_item(pack_item(1'b1, 1'b1, 2'd3, 2'd3));
        repeat (8) send_item(pack_item(1'b0, 1'b1, 2'd2, 2'd1));
        finish_messages();

        // zero lengths, zero gap, zero repeat count, all-zero id
        set_config('0);
        send_item(pack_item(1'b1, 1'b1, 2'd1, 2'd2));
        repeat (6) send_item(pack_item(1'b0, 1'b0, 2'd0, 2'd0));
        send_item(pack_item(1'b1, 1'b0, 2'd2, 2'd1));
        finish_messages();
        send_item(pack_item(1'b1, 1'b0, 2'd2, 2'd1));
        finish_messages();

        // longest settings, no idling on either side
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        set_config('1);
        random_items(30);
        finish_messages();

        for (int p = 0; p < 6; p++)
        begin
            tx_gaps = (p != 2);
            rx_stalls = (p != 4);
            set_config(small_config());
            random_items(120);
            finish_messages();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
